FILE: design/tdc_pkg.sv
package tdc_pkg;

	// Operation codes carried in s_axis_tuser
	typedef enum logic [2:0] {
		OP_INC      = 3'd0,
		OP_DEC      = 3'd1,
		OP_ADD      = 3'd2,
		OP_SET_ALL  = 3'd3,
		OP_SET_HOUR = 3'd4,
		OP_SET_MIN  = 3'd5,
		OP_SET_SEC  = 3'd6,
		OP_LOAD     = 3'd7
	} tdc_op_t;

	localparam logic [16:0] DAY_SECS  = 17'd86400;
	localparam logic [16:0] DAY_LAST  = 17'd86399;
	localparam logic [11:0] HOUR_SECS = 12'd3600;
	localparam logic [5:0]  MIN_SECS  = 6'd60;
	localparam logic [4:0]  HOURS_DAY = 5'd24;
	localparam logic [4:0]  MAX_HOUR  = 5'd23;
	localparam logic [5:0]  MAX_MINSEC = 6'd59;

	// 86400 = 128 * 675: reduce the upper 25 bits modulo 675
	localparam logic [9:0]  MOD_ODD    = 10'd675;
	localparam logic [24:0] MOD_RECIP  = 25'd25451658;  // floor(2^34 / 675)
	localparam int          MOD_SHIFT  = 34;
	// 2^32 mod 86400 and its complement, for negative words
	localparam logic [16:0] WRAP32     = 17'd23296;
	localparam logic [16:0] WRAP32_C   = 17'd63104;

	localparam logic [17:0] HOUR_RECIP = 18'd149131;    // ceil(2^29 / 3600)
	localparam int          HOUR_SHIFT = 29;
	localparam logic [11:0] MIN_RECIP  = 12'd2185;      // ceil(2^17 / 60)
	localparam int          MIN_SHIFT  = 17;

	typedef struct packed {
		tdc_op_t    op;
		logic [4:0] hour_val;
		logic [5:0] min_val;
		logic [5:0] sec_val;
	} tdc_cmd_t;

	// Command plus its second amount split into hour / minute / second digits
	typedef struct packed {
		tdc_cmd_t   cmd;
		logic [4:0] dh;
		logic [5:0] dm;
		logic [5:0] ds;
	} tdc_delta_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic       rejected;
	} tdc_time_t;

endpackage

FILE: design/tdc_reduce.sv
module tdc_reduce import tdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  tdc_cmd_t    in_cmd,
	input  logic [31:0] in_amount,
	output logic        out_valid,
	input  logic        out_ready,
	output tdc_delta_t  out_item
);

	logic [8:1] vld_q;
	logic [8:1] adv;

	tdc_cmd_t    cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6, cmd_s7;
	logic [31:0] amt_s1;
	logic [24:0] x_s2;
	logic [6:0]  low_s2, low_s3;
	logic        neg_s2, neg_s3;
	logic [15:0] q_s2;
	logic [10:0] r0_s3;
	logic [16:0] v_s4, v_s5;
	logic [4:0]  h_s5, h_s6, h_s7;
	logic [11:0] rem_s6, rem_s7;
	logic [5:0]  m_s7;
	tdc_delta_t  item_s8;

	logic [49:0] prod1;
	logic [25:0] qm2;
	logic [25:0] r0_full;
	logic [10:0] r3;
	logic [16:0] um;
	logic [16:0] adj;
	logic [16:0] v3;
	logic [34:0] prod4;
	logic [16:0] rem5;
	logic [23:0] prod6;
	logic [11:0] sec7;

	// Stage advances when empty or when the next one advances
	always_comb begin
		adv[8] = !vld_q[8] || out_ready;
		for (int i = 7; i >= 1; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign in_ready  = adv[1];
	assign out_valid = vld_q[8];
	assign out_item  = item_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) vld_q[1] <= in_valid;
			for (int i = 2; i <= 8; i++) begin
				if (adv[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign prod1   = 50'(amt_s1[31:7]) * 50'(MOD_RECIP);
	assign qm2     = 26'(q_s2) * 26'(MOD_ODD);
	assign r0_full = 26'(x_s2) - qm2;

	always_comb begin
		r3  = (r0_s3 >= 11'(MOD_ODD)) ? r0_s3 - 11'(MOD_ODD) : r0_s3;
		um  = {r3[9:0], low_s3};
		adj = (um >= WRAP32) ? um - WRAP32 : um + WRAP32_C;
		unique case (cmd_s3.op)
			OP_INC:  v3 = 17'd1;
			OP_DEC:  v3 = DAY_LAST;
			OP_ADD:  v3 = neg_s3 ? adj : um;
			OP_LOAD: v3 = neg_s3 ? '0 : um;
			default: v3 = '0;
		endcase
	end

	assign prod4 = 35'(v_s4) * 35'(HOUR_RECIP);
	assign rem5  = v_s5 - 17'(h_s5) * 17'(HOUR_SECS);
	assign prod6 = 24'(rem_s6) * 24'(MIN_RECIP);
	assign sec7  = rem_s7 - 12'(m_s7) * 12'(MIN_SECS);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			cmd_s1 <= in_cmd;
			amt_s1 <= in_amount;
		end
		if (adv[2]) begin
			cmd_s2 <= cmd_s1;
			x_s2   <= amt_s1[31:7];
			low_s2 <= amt_s1[6:0];
			neg_s2 <= amt_s1[31];
			q_s2   <= prod1[MOD_SHIFT+15:MOD_SHIFT];
		end
		if (adv[3]) begin
			cmd_s3 <= cmd_s2;
			r0_s3  <= r0_full[10:0];
			low_s3 <= low_s2;
			neg_s3 <= neg_s2;
		end
		if (adv[4]) begin
			cmd_s4 <= cmd_s3;
			v_s4   <= v3;
		end
		if (adv[5]) begin
			cmd_s5 <= cmd_s4;
			v_s5   <= v_s4;
			h_s5   <= prod4[HOUR_SHIFT+4:HOUR_SHIFT];
		end
		if (adv[6]) begin
			cmd_s6 <= cmd_s5;
			h_s6   <= h_s5;
			rem_s6 <= rem5[11:0];
		end
		if (adv[7]) begin
			cmd_s7 <= cmd_s6;
			h_s7   <= h_s6;
			rem_s7 <= rem_s6;
			m_s7   <= prod6[MIN_SHIFT+5:MIN_SHIFT];
		end
		if (adv[8]) begin
			item_s8.cmd <= cmd_s7;
			item_s8.dh  <= h_s7;
			item_s8.dm  <= m_s7;
			item_s8.ds  <= sec7[5:0];
		end
	end

endmodule

FILE: design/tdc_update.sv
module tdc_update import tdc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  tdc_delta_t in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output tdc_time_t  out_time
);

	logic [4:0] hour_q;
	logic [5:0] minute_q;
	logic [5:0] second_q;
	logic       res_valid_q;
	tdc_time_t  res_s9;

	logic       take;
	logic [6:0] s_sum, m_sum;
	logic [5:0] h_sum;
	logic       c_sec, c_min;
	logic [4:0] h_add;
	logic [5:0] m_add, s_add;
	tdc_time_t  nxt;

	assign in_ready  = !res_valid_q || out_ready;
	assign take      = in_valid && in_ready;
	assign out_valid = res_valid_q;
	assign out_time  = res_s9;

	// Mixed-radix add of the digit delta with carries
	always_comb begin
		s_sum = 7'(second_q) + 7'(in_item.ds);
		c_sec = s_sum >= 7'(MIN_SECS);
		s_add = c_sec ? 6'(s_sum - 7'(MIN_SECS)) : s_sum[5:0];
		m_sum = 7'(minute_q) + 7'(in_item.dm) + 7'(c_sec);
		c_min = m_sum >= 7'(MIN_SECS);
		m_add = c_min ? 6'(m_sum - 7'(MIN_SECS)) : m_sum[5:0];
		h_sum = 6'(hour_q) + 6'(in_item.dh) + 6'(c_min);
		h_add = (h_sum >= 6'(HOURS_DAY)) ? 5'(h_sum - 6'(HOURS_DAY)) : h_sum[4:0];
	end

	always_comb begin
		nxt.hour     = hour_q;
		nxt.minute   = minute_q;
		nxt.second   = second_q;
		nxt.rejected = 1'b0;
		unique case (in_item.cmd.op)
			OP_INC, OP_DEC, OP_ADD: begin
				nxt.hour   = h_add;
				nxt.minute = m_add;
				nxt.second = s_add;
			end
			OP_LOAD: begin
				nxt.hour   = in_item.dh;
				nxt.minute = in_item.dm;
				nxt.second = in_item.ds;
			end
			OP_SET_ALL: begin
				if (in_item.cmd.hour_val > MAX_HOUR || in_item.cmd.min_val > MAX_MINSEC ||
				    in_item.cmd.sec_val > MAX_MINSEC) begin
					nxt.hour   = '0;
					nxt.minute = '0;
					nxt.second = '0;
				end else begin
					nxt.hour   = in_item.cmd.hour_val;
					nxt.minute = in_item.cmd.min_val;
					nxt.second = in_item.cmd.sec_val;
				end
			end
			OP_SET_HOUR: begin
				if (in_item.cmd.hour_val > MAX_HOUR) nxt.rejected = 1'b1;
				else nxt.hour = in_item.cmd.hour_val;
			end
			OP_SET_MIN: begin
				if (in_item.cmd.min_val > MAX_MINSEC) nxt.rejected = 1'b1;
				else nxt.minute = in_item.cmd.min_val;
			end
			OP_SET_SEC: begin
				if (in_item.cmd.sec_val > MAX_MINSEC) nxt.rejected = 1'b1;
				else nxt.second = in_item.cmd.sec_val;
			end
			// stage register holds no word yet: hold the time
			default: begin
				nxt.rejected = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q      <= '0;
			minute_q    <= '0;
			second_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (in_ready) res_valid_q <= in_valid;
			if (take) begin
				hour_q   <= nxt.hour;
				minute_q <= nxt.minute;
				second_q <= nxt.second;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_s9 <= nxt;
	end

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		hour_q <= MAX_HOUR && minute_q <= MAX_MINSEC && second_q <= MAX_MINSEC)
		else $error("time register out of range");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		take && nxt.rejected |=> $stable(hour_q) && $stable(minute_q) && $stable(second_q))
		else $error("rejected set changed the time");

	a_reject_op: assert property (@(posedge clk) disable iff (!arst_n)
		take && nxt.rejected |-> (in_item.cmd.op == OP_SET_HOUR ||
		in_item.cmd.op == OP_SET_MIN || in_item.cmd.op == OP_SET_SEC))
		else $error("reject flagged for an operation that cannot reject");

endmodule

FILE: design/time_of_day_clock_unit.sv
// Time-of-day clock. Holds hour, minute and second and applies one operation per input
// word, selected by s_axis_tuser: step forward, step back, add a signed second count,
// set all fields, set one field, or load from a second count; all arithmetic wraps at
// 86400 seconds. Every input word gives exactly one output word with the new time, its
// second-of-day count and a reject flag for an out-of-range single-field set. One word
// is taken per clock when the output side keeps up; a result is then registered in
// the update and output stages. The amount is reduced modulo 86400 and split into
// hour/minute/second digits in an eight-stage pipeline ahead of the time registers,
// so the only per-cycle dependency is a short mixed-radix carry add in the update
// stage. Bubbles collapse, so input words keep flowing while a result waits.
module time_of_day_clock_unit import tdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] seconds_amount, [36:32] hour_value, [42:37] minute_value,
	// [48:43] second_value, [55:49] zero
	input  logic [55:0] s_axis_tdata,
	// [2:0] operation
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [4:0] hour_now, [10:5] minute_now, [16:11] second_now, [33:17] day_seconds,
	// [39:34] zero
	output logic [39:0] m_axis_tdata,
	// [0] rejected
	output logic        m_axis_tuser
);

	tdc_cmd_t    in_cmd;
	tdc_delta_t  delta;
	logic        delta_valid, delta_ready;
	tdc_time_t   res;
	logic        res_valid;
	logic        out_adv;
	logic [16:0] day_sum;

	logic        out_valid_q;
	tdc_time_t   out_time_q;
	logic [16:0] day_q;

	// Unpack the input word
	assign in_cmd.op       = tdc_op_t'(s_axis_tuser);
	assign in_cmd.hour_val = s_axis_tdata[36:32];
	assign in_cmd.min_val  = s_axis_tdata[42:37];
	assign in_cmd.sec_val  = s_axis_tdata[48:43];

	tdc_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (in_cmd),
		.in_amount (s_axis_tdata[31:0]),
		.out_valid (delta_valid),
		.out_ready (delta_ready),
		.out_item  (delta)
	);

	tdc_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (delta_valid),
		.in_ready  (delta_ready),
		.in_item   (delta),
		.out_valid (res_valid),
		.out_ready (out_adv),
		.out_time  (res)
	);

	// Output register: load when empty or when the word is being taken
	assign out_adv = !out_valid_q || m_axis_tready;

	// Second-of-day count from the new time
	assign day_sum = 17'(res.hour) * 17'(HOUR_SECS) + 17'(res.minute) * 17'(MIN_SECS)
		+ 17'(res.second);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && res_valid) begin
			out_time_q <= res;
			day_q      <= day_sum;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, day_q, out_time_q.second, out_time_q.minute,
		out_time_q.hour};
	assign m_axis_tuser  = out_time_q.rejected;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled with an empty output register");

	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> day_q <= DAY_LAST)
		else $error("second-of-day count out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_time_q.hour <= MAX_HOUR && out_time_q.minute <= MAX_MINSEC &&
		out_time_q.second <= MAX_MINSEC)
		else $error("output time out of range");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import tdc_pkg::*;

	localparam int CYCLE_LIMIT  = 200_000;
	localparam int RANDOM_WORDS = 1250;
	localparam int DRAIN_CYCLES = 24;
	localparam int IDLE_PCT     = 18;

	// One command word, with an optional hand-written expected time.
	typedef struct {
		tdc_op_t     op;
		logic [31:0] amount;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		bit          pinned;
		logic [4:0]  exp_hour;
		logic [5:0]  exp_minute;
		logic [5:0]  exp_second;
		bit          exp_rejected;
	} clock_cmd_t;

	typedef struct {
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [16:0] day_secs;
		logic        rejected;
	} clock_time_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;

	// Shadow copy of the time registers, advanced as each word is taken.
	logic [4:0]  tod_hour;
	logic [5:0]  tod_minute;
	logic [5:0]  tod_second;

	clock_time_t expected_times[$];
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit          steady = 1'b0;   // set during the stretch with no idling on either side

	// Directed words: wrap points, every operation, out-of-range sets and the count
	// extremes. Rows with pinned = 1 carry their expected time; the rest are predicted.
	clock_cmd_t directed_words [25] = '{
		'{OP_INC,      32'd0,          5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd1,  1'b0},
		'{OP_DEC,      32'd0,          5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0,  1'b0},
		'{OP_DEC,      32'hFFFF_FFFF,  5'd31, 6'd63, 6'd63, 1'b1, 5'd23, 6'd59, 6'd59, 1'b0},
		'{OP_INC,      32'hFFFF_FFFF,  5'd31, 6'd63, 6'd63, 1'b1, 5'd0,  6'd0,  6'd0,  1'b0},
		'{OP_SET_ALL,  32'd0,          5'd23, 6'd59, 6'd59, 1'b1, 5'd23, 6'd59, 6'd59, 1'b0},
		'{OP_INC,      32'd0,          5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0,  1'b0},
		'{OP_SET_ALL,  32'd0,          5'd24, 6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0,  1'b0},
		'{OP_SET_ALL,  32'd0,          5'd12, 6'd30, 6'd45, 1'b1, 5'd12, 6'd30, 6'd45, 1'b0},
		'{OP_SET_ALL,  32'd0,          5'd5,  6'd60, 6'd0,  1'b1, 5'd0,  6'd0,  6'd0,  1'b0},
		'{OP_SET_ALL,  32'd0,          5'd31, 6'd63, 6'd63, 1'b1, 5'd0,  6'd0,  6'd0,  1'b0},
		'{OP_SET_HOUR, 32'd0,          5'd31, 6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0,  1'b1},
		'{OP_SET_HOUR, 32'd0,          5'd23, 6'd63, 6'd63, 1'b1, 5'd23, 6'd0,  6'd0,  1'b0},
		'{OP_SET_MIN,  32'd0,          5'd0,  6'd60, 6'd0,  1'b1, 5'd23, 6'd0,  6'd0,  1'b1},
		'{OP_SET_MIN,  32'd0,          5'd31, 6'd59, 6'd63, 1'b1, 5'd23, 6'd59, 6'd0,  1'b0},
		'{OP_SET_SEC,  32'd0,          5'd0,  6'd0,  6'd63, 1'b1, 5'd23, 6'd59, 6'd0,  1'b1},
		'{OP_SET_SEC,  32'd0,          5'd31, 6'd63, 6'd59, 1'b1, 5'd23, 6'd59, 6'd59, 1'b0},
		'{OP_LOAD,     32'hFFFF_FFFF,  5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0,  1'b0},
		'{OP_LOAD,     32'd86399,      5'd0,  6'd0,  6'd0,  1'b1, 5'd23, 6'd59, 6'd59, 1'b0},
		'{OP_LOAD,     32'd86400,      5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0,  1'b0},
		'{OP_LOAD,     32'h7FFF_FFFF,  5'd0,  6'd0,  6'd0,  1'b1, 5'd3,  6'd14, 6'd7,  1'b0},
		'{OP_LOAD,     32'h8000_0000,  5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0,  1'b0},
		'{OP_ADD,      32'h7FFF_FFFF,  5'd0,  6'd0,  6'd0,  1'b0, 5'd0,  6'd0,  6'd0,  1'b0},
		'{OP_ADD,      32'h8000_0000,  5'd0,  6'd0,  6'd0,  1'b0, 5'd0,  6'd0,  6'd0,  1'b0},
		'{OP_ADD,      32'hFFFF_FFFF,  5'd0,  6'd0,  6'd0,  1'b0, 5'd0,  6'd0,  6'd0,  1'b0},
		'{OP_ADD,      32'd86400,      5'd0,  6'd0,  6'd0,  1'b0, 5'd0,  6'd0,  6'd0,  1'b0}
	};

	time_of_day_clock_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #4 clk = ~clk;

	// Reduce a signed second count to the day with floor modulo and split it.
	function automatic void load_day_count(input longint count);
		longint r;
		r = count % 86400;
		if (r < 0) r += 86400;
		tod_second = 6'(r % 60);
		tod_minute = 6'((r / 60) % 60);
		tod_hour   = 5'(r / 3600);
	endfunction

	// Apply one command to the shadow registers and return the time it leaves behind.
	function automatic clock_time_t predict_time(input clock_cmd_t c);
		clock_time_t t;
		longint      now;
		longint      amt;
		now = longint'(tod_hour) * 3600 + longint'(tod_minute) * 60 + longint'(tod_second);
		amt = longint'($signed(c.amount));
		t.rejected = 1'b0;
		case (c.op)
			OP_INC: load_day_count(now + 1);
			OP_DEC: load_day_count(now - 1);
			OP_ADD: load_day_count(now + amt);
			OP_SET_ALL: begin
				if (c.hour > 5'd23 || c.minute > 6'd59 || c.second > 6'd59) begin
					tod_hour   = '0;
					tod_minute = '0;
					tod_second = '0;
				end else begin
					tod_hour   = c.hour;
					tod_minute = c.minute;
					tod_second = c.second;
				end
			end
			OP_SET_HOUR: if (c.hour > 5'd23) t.rejected = 1'b1; else tod_hour = c.hour;
			OP_SET_MIN: if (c.minute > 6'd59) t.rejected = 1'b1; else tod_minute = c.minute;
			OP_SET_SEC: if (c.second > 6'd59) t.rejected = 1'b1; else tod_second = c.second;
			default: load_day_count(amt < 0 ? 0 : amt);
		endcase
		t.hour     = tod_hour;
		t.minute   = tod_minute;
		t.second   = tod_second;
		t.day_secs = 17'(int'(tod_hour) * 3600 + int'(tod_minute) * 60 + int'(tod_second));
		return t;
	endfunction

	// Present one word, hold it until taken, then queue its expected time.
	task automatic send_word(input clock_cmd_t c);
		clock_time_t predicted;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, c.second, c.minute, c.hour, c.amount};
		s_axis_tuser  <= c.op;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predicted = predict_time(c);
		if (c.pinned) begin
			predicted.hour     = c.exp_hour;
			predicted.minute   = c.exp_minute;
			predicted.second   = c.exp_second;
			predicted.rejected = c.exp_rejected;
			predicted.day_secs = 17'(int'(c.exp_hour) * 3600 + int'(c.exp_minute) * 60
				+ int'(c.exp_second));
		end
		expected_times.push_back(predicted);
	endtask

	// Random command: mostly in-range set values, amounts spread from small steps to
	// the 32-bit extremes.
	function automatic clock_cmd_t random_word();
		clock_cmd_t  c;
		logic [2:0]  code;
		int unsigned off;
		code = 3'($urandom_range(0, 7));
		c.op = tdc_op_t'(code);
		off  = $urandom_range(0, 300);
		case ($urandom_range(0, 3))
			0: c.amount = 32'($signed($urandom_range(0, 600)) - 300);
			1: c.amount = 32'($signed($urandom_range(0, 400000)) - 200000);
			2: c.amount = $urandom;
			default: begin
				case ($urandom_range(0, 3))
					0: c.amount = 32'h7FFF_FFFF - off;
					1: c.amount = 32'h8000_0000 + off;
					2: c.amount = 32'd86400 * $urandom_range(0, 3) + off - 150;
					default: c.amount = 32'hFFFE_AE80 + off - 150;  // about minus one day
				endcase
			end
		endcase
		c.hour   = ($urandom_range(0, 99) < 75) ? 5'($urandom_range(0, 23)) : 5'($urandom);
		c.minute = ($urandom_range(0, 99) < 75) ? 6'($urandom_range(0, 59)) : 6'($urandom);
		c.second = ($urandom_range(0, 99) < 75) ? 6'($urandom_range(0, 59)) : 6'($urandom);
		c.pinned = 1'b0;
		c.exp_hour = '0;
		c.exp_minute = '0;
		c.exp_second = '0;
		c.exp_rejected = 1'b0;
		return c;
	endfunction

	task automatic report_field(input string what, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	// Stall the result side at random, except during the steady stretch.
	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Compare each taken result word with the oldest expectation.
	always @(posedge clk) begin
		clock_time_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_times.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result word, expected none, actual %h/%b", $time,
					m_axis_tdata, m_axis_tuser);
			end else begin
				want = expected_times.pop_front();
				report_field("hour_now", want.hour, m_axis_tdata[4:0]);
				report_field("minute_now", want.minute, m_axis_tdata[10:5]);
				report_field("second_now", want.second, m_axis_tdata[16:11]);
				report_field("day_seconds", want.day_secs, m_axis_tdata[33:17]);
				report_field("rejected", want.rejected, m_axis_tuser);
			end
		end
	end

	// Watchdog: drop out if the run hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		tod_hour   = '0;
		tod_minute = '0;
		tod_second = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		foreach (directed_words[i]) send_word(directed_words[i]);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// hold both sides busy for a long stretch in the middle
			steady = (n >= 500 && n < 700);
			send_word(random_word());
		end
		steady = 1'b0;
		s_axis_tvalid <= 1'b0;

		// wait for the pipeline to drain, then a little longer for stray words
		while (expected_times.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_times.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
design/tdc_pkg.sv
design/tdc_reduce.sv
design/tdc_update.sv
design/time_of_day_clock_unit.sv
sim/tb_top.sv
